@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/q4k_pkg.sv @@
`default_nettype none
package q4k_pkg;

  localparam int unsigned BlockBytes = 144;
  localparam int unsigned ScaleBase  = 4;
  localparam int unsigned ScaleLast  = 15;
  localparam int unsigned NibbleBase = 16;
  localparam int unsigned ScaleRegs  = 11;
  localparam int unsigned NumGroups  = 8;

  typedef enum logic [1:0] {
    KindScale   = 2'd0,
    KindMin     = 2'd1,
    KindProduct = 2'd2
  } q4k_kind_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [7:0] pos;
  } q4k_item_t;

  typedef struct packed {
    logic [5:0] scale0;
    logic [5:0] min0;
    logic [5:0] scale1;
    logic [5:0] min1;
  } q4k_grp_t;

endpackage
`default_nettype wire

@@ hw/rtl/q4k_half_cvt.sv @@
`default_nettype none
module q4k_half_cvt (
  input  logic [15:0] half_i,
  output logic [31:0] single_o
);

  logic [4:0] e;
  logic [9:0] m;
  logic [3:0] lead;
  logic [3:0] shamt;
  logic [7:0] sub_exp;
  logic [9:0] sub_man;
  logic [7:0] norm_exp;
  logic [30:0] mag;

  assign e = half_i[14:10];
  assign m = half_i[9:0];

  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        lead = 4'(i);
      end
    end
  end

  assign shamt    = 4'd10 - lead;
  assign sub_exp  = 8'd103 + {4'b0, lead};
  assign sub_man  = m << shamt;
  assign norm_exp = {3'b0, e} + 8'd112;

  always_comb begin
    priority if (e == 5'd0 && m == 10'd0) begin
      mag = '0;
    end else if (e == 5'd0) begin
      mag = {sub_exp, sub_man, 13'd0};
    end else if (e == 5'h1f) begin
      mag = {8'hff, m, 13'd0};
    end else begin
      mag = {norm_exp, m, 13'd0};
    end
  end

  assign single_o = {half_i[15], mag};

endmodule
`default_nettype wire

@@ hw/rtl/q4k_group_regs.sv @@
`default_nettype none
module q4k_group_regs (
  input  logic               clk_i,
  input  logic               step_i,
  input  q4k_pkg::q4k_item_t item_i,
  output q4k_pkg::q4k_grp_t  grp_o
);
  import q4k_pkg::*;

  logic [7:0]  raw_q [ScaleRegs];
  logic [11:0] grp_q [NumGroups];
  logic [11:0] grp_d [NumGroups];
  logic [7:0]  all_b [ScaleRegs + 1];
  logic [7:0]  off;
  logic [3:0]  widx;
  logic [4:0]  nib_j;
  logic        wr_raw;
  logic        load_grp;
  logic        rot_grp;

  assign off      = item_i.pos - 8'(ScaleBase);
  assign widx     = off[3:0];
  assign nib_j    = 5'(item_i.pos - 8'(NibbleBase));
  assign wr_raw   = step_i && item_i.pos >= 8'(ScaleBase) && item_i.pos < 8'(ScaleLast);
  assign load_grp = step_i && item_i.pos == 8'(ScaleLast);
  // chunk boundaries: last byte of each 32-byte chunk
  assign rot_grp  = step_i && item_i.pos >= 8'(NibbleBase) && nib_j == 5'h1f;

  always_comb begin
    for (int k = 0; k < ScaleRegs; k++) begin
      all_b[k] = raw_q[k];
    end
    all_b[ScaleRegs] = item_i.byte_value;
  end

  // group entry: {scale, min}
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_d[g]     = {all_b[g][5:0], all_b[g+4][5:0]};
      grp_d[g + 4] = {all_b[g][7:6], all_b[g+8][3:0], all_b[g+4][7:6], all_b[g+8][7:4]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_raw) begin
      raw_q[widx] <= item_i.byte_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_grp) begin
      for (int g = 0; g < NumGroups; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end else if (rot_grp) begin
      for (int g = 0; g < NumGroups - 2; g++) begin
        grp_q[g] <= grp_q[g + 2];
      end
    end
  end

  assign grp_o.scale0 = grp_q[0][11:6];
  assign grp_o.min0   = grp_q[0][5:0];
  assign grp_o.scale1 = grp_q[1][11:6];
  assign grp_o.min1   = grp_q[1][5:0];

endmodule
`default_nettype wire

@@ hw/rtl/q4k_block_scale_product_unpacker_top.sv @@
`default_nettype none
// Q4_K super-block unpacker. Bytes of a 144-byte super-block enter one per
// transaction on the input channel (block_start_i marks byte 0; the byte
// counter also wraps after byte 143 on its own). Bytes 1 and 3 give the
// super-scale and super-min as float32 bits, each nibble byte from 16 on
// gives two scaled products with their position and group mins, and the
// remaining bytes give no result. One transaction is accepted every cycle
// while the input is not stalled; a byte is captured in an input register,
// and its result is loaded from there into the result register through one
// combinational step. The input stalls only while the result register holds
// an untaken result and the output side stalls.
module q4k_block_scale_product_unpacker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        block_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  position_o,
  output logic [9:0]  weight_low_o,
  output logic [9:0]  weight_high_o,
  output logic [5:0]  min_low_o,
  output logic [5:0]  min_high_o,
  output logic [31:0] float_bits_o
);
  import q4k_pkg::*;

  logic       in_acc;
  logic       adv;
  logic       s1_go;
  logic [7:0] cnt_q, cnt_d, pos_cur;
  logic       s1_v_q, s1_v_d;
  q4k_item_t  s1_q;
  logic [7:0] half_low_q;
  logic       out_v_q, out_v_d;

  logic       is_half_lo, is_scale_hi, is_min_hi, is_nib, res_has;
  q4k_grp_t   grp;
  logic [31:0] fbits;
  logic [7:0] q_off;
  q4k_kind_e  kind_d;
  logic [7:0] pos_d;
  logic [9:0] wlo_d, whi_d;
  logic [5:0] mlo_d, mhi_d;
  logic [31:0] fb_d;

  logic [1:0]  kind_q;
  logic [7:0]  pos_q;
  logic [9:0]  wlo_q, whi_q;
  logic [5:0]  mlo_q, mhi_q;
  logic [31:0] fb_q;

  assign adv        = !out_v_q || !out_stall_i;
  assign s1_go      = s1_v_q && adv;
  assign in_stall_o = s1_v_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pos_cur = block_start_i ? 8'd0 : cnt_q;
  assign cnt_d   = (pos_cur == 8'(BlockBytes - 1)) ? 8'd0 : pos_cur + 8'd1;
  assign s1_v_d  = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      if (in_acc) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.byte_value <= byte_value_i;
      s1_q.pos        <= pos_cur;
    end
  end

  assign is_half_lo  = s1_q.pos == 8'd0 || s1_q.pos == 8'd2;
  assign is_scale_hi = s1_q.pos == 8'd1;
  assign is_min_hi   = s1_q.pos == 8'd3;
  assign is_nib      = s1_q.pos >= 8'(NibbleBase);
  assign res_has     = is_scale_hi || is_min_hi || is_nib;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_low_q <= '0;
    end else if (s1_go && is_half_lo) begin
      half_low_q <= s1_q.byte_value;
    end
  end

  q4k_group_regs u_grp (
    .clk_i  (clk_i),
    .step_i (s1_go),
    .item_i (s1_q),
    .grp_o  (grp)
  );

  q4k_half_cvt u_cvt (
    .half_i   ({s1_q.byte_value, half_low_q}),
    .single_o (fbits)
  );

  assign q_off = s1_q.pos - 8'(NibbleBase);

  always_comb begin
    kind_d = KindProduct;
    pos_d  = '0;
    wlo_d  = '0;
    whi_d  = '0;
    mlo_d  = '0;
    mhi_d  = '0;
    fb_d   = '0;
    if (is_nib) begin
      pos_d = {q_off[6:5], 1'b0, q_off[4:0]};
      wlo_d = {6'd0, s1_q.byte_value[3:0]} * {4'd0, grp.scale0};
      whi_d = {6'd0, s1_q.byte_value[7:4]} * {4'd0, grp.scale1};
      mlo_d = grp.min0;
      mhi_d = grp.min1;
    end else begin
      kind_d = is_scale_hi ? KindScale : KindMin;
      fb_d   = fbits;
    end
  end

  assign out_v_d = adv ? (s1_v_q && res_has) : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res_has) begin
      kind_q <= kind_d;
      pos_q  <= pos_d;
      wlo_q  <= wlo_d;
      whi_q  <= whi_d;
      mlo_q  <= mlo_d;
      mhi_q  <= mhi_d;
      fb_q   <= fb_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = kind_q;
  assign position_o    = pos_q;
  assign weight_low_o  = wlo_q;
  assign weight_high_o = whi_q;
  assign min_low_o     = mlo_q;
  assign min_high_o    = mhi_q;
  assign float_bits_o  = fb_q;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q < 8'(BlockBytes))
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `ASSERT_NEXT(a_scale_out, clk_i, rst_ni, s1_go && is_scale_hi,
               out_valid_o && kind_o == KindScale)
  `ASSERT_IMPL(a_float_clean, clk_i, rst_ni, out_valid_o && kind_o != KindProduct,
               position_o == 8'd0 && weight_low_o == 10'd0)

endmodule
`default_nettype wire
